FILE: rtl/bresenham_line_rasterizer_core_assert.svh
// Assertion macros for the line rasterizer core.
// Used by bresenham_line_rasterizer_core.sv; no other dependencies.
`ifndef BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define BRL_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Condition in this cycle implies a consequence in the next one.
`define BRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRL_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define BRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/brl_pkg.sv
// Shared constants for the line rasterizer core.
// No dependencies.
package brl_pkg;

    localparam int COORD_BITS_DEF = 8;   // internal coordinate width
    localparam int FIELD_BITS     = 8;   // width of coordinate ports

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage

FILE: rtl/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer core: load/step walk with a registered result stage.
// Depends on brl_pkg and bresenham_line_rasterizer_core_assert.svh.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_ready    | op, x/y start, x/y end, color
//   out     | output    | o_out_valid / i_out_ready  | pixel_x, pixel_y, pixel_color, last
//
// One transaction per cycle on the input while o_in_ready is high; a step's pixel appears
// in the cycle after acceptance, from the result register, while the walk advances by one
// add-and-compare. Load transactions and steps while idle produce no output.
// The output register parts the channels: input is taken while a pixel waits if the
// sink takes it in the same cycle. Synchronous active-low reset clears to idle.
`include "bresenham_line_rasterizer_core_assert.svh"

module bresenham_line_rasterizer_core #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [brl_pkg::FIELD_BITS-1:0]  i_x_start,
    input  logic [brl_pkg::FIELD_BITS-1:0]  i_y_start,
    input  logic [brl_pkg::FIELD_BITS-1:0]  i_x_end,
    input  logic [brl_pkg::FIELD_BITS-1:0]  i_y_end,
    input  logic                            i_color,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [brl_pkg::FIELD_BITS-1:0]  o_pixel_x,
    output logic [brl_pkg::FIELD_BITS-1:0]  o_pixel_y,
    output logic                            o_pixel_color,
    output logic                            o_last
);
    import brl_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int EW = COORD_BITS + 3;   // signed error term
    localparam int XW = COORD_BITS + FIELD_BITS;

    // walk state
    logic [W-1:0]          r_major_pos, r_minor_pos, r_major_delta, r_minor_delta;
    logic signed [EW-1:0]  r_error;
    logic                  r_major_neg, r_minor_neg, r_swapped, r_color, r_active;
    logic [W:0]            r_pixels_left;

    logic [W-1:0]          n_major_pos, n_minor_pos, n_major_delta, n_minor_delta;
    logic signed [EW-1:0]  n_error;
    logic                  n_major_neg, n_minor_neg, n_swapped, n_color, n_active;
    logic [W:0]            n_pixels_left;

    // result register
    logic                  r_out_valid;
    logic [FIELD_BITS-1:0] r_px, r_py;
    logic                  r_pcolor, r_plast;

    logic in_fire, out_fire, step_emit, is_last;

    // coordinate width conversion (zero-extend or truncate)
    logic [XW-1:0] x0_ext, y0_ext, x1_ext, y1_ext;
    logic [W-1:0]  x0, y0, x1, y1, dx, dy;
    logic          xneg, yneg, swap;
    logic [W-1:0]  ld_major, ld_minor;
    logic [XW-1:0] px_ext, py_ext;
    logic [W-1:0]  cur_x, cur_y;
    logic signed [EW-1:0] two_minor, two_major;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = r_out_valid && i_out_ready;
    assign step_emit  = in_fire && (i_op == OP_STEP) && r_active;
    assign is_last    = (r_pixels_left <= (W+1)'(1));

    assign x0_ext = {{W{1'b0}}, i_x_start};
    assign y0_ext = {{W{1'b0}}, i_y_start};
    assign x1_ext = {{W{1'b0}}, i_x_end};
    assign y1_ext = {{W{1'b0}}, i_y_end};
    assign x0 = x0_ext[W-1:0];
    assign y0 = y0_ext[W-1:0];
    assign x1 = x1_ext[W-1:0];
    assign y1 = y1_ext[W-1:0];

    assign xneg = !(x1 > x0);
    assign yneg = !(y1 > y0);
    assign dx   = xneg ? (x0 - x1) : (x1 - x0);
    assign dy   = yneg ? (y0 - y1) : (y1 - y0);
    assign swap = dy > dx;   // equal deltas keep x as major
    assign ld_major = swap ? dy : dx;
    assign ld_minor = swap ? dx : dy;

    assign two_minor = $signed({2'b00, r_minor_delta, 1'b0});
    assign two_major = $signed({2'b00, r_major_delta, 1'b0});

    always_comb begin
        n_major_pos   = r_major_pos;
        n_minor_pos   = r_minor_pos;
        n_major_delta = r_major_delta;
        n_minor_delta = r_minor_delta;
        n_error       = r_error;
        n_major_neg   = r_major_neg;
        n_minor_neg   = r_minor_neg;
        n_swapped     = r_swapped;
        n_color       = r_color;
        n_active      = r_active;
        n_pixels_left = r_pixels_left;
        if (in_fire && (i_op == OP_LOAD)) begin
            n_swapped     = swap;
            n_major_pos   = swap ? y0 : x0;
            n_minor_pos   = swap ? x0 : y0;
            n_major_delta = ld_major;
            n_minor_delta = ld_minor;
            n_major_neg   = swap ? yneg : xneg;
            n_minor_neg   = swap ? xneg : yneg;
            n_error       = $signed({2'b00, ld_minor, 1'b0}) - $signed({3'b000, ld_major});
            n_pixels_left = {1'b0, ld_major} + (W+1)'(1);
            n_color       = i_color;
            n_active      = 1'b1;
        end else if (step_emit) begin
            if (is_last) begin
                n_pixels_left = '0;
                n_active      = 1'b0;
            end else begin
                n_pixels_left = r_pixels_left - (W+1)'(1);
                n_major_pos   = r_major_neg ? (r_major_pos - W'(1)) : (r_major_pos + W'(1));
                if (r_error >= 0) begin
                    n_minor_pos = r_minor_neg ? (r_minor_pos - W'(1))
                                              : (r_minor_pos + W'(1));
                    n_error     = r_error - two_major + two_minor;
                end else begin
                    n_error     = r_error + two_minor;
                end
            end
        end
    end

    assign cur_x  = r_swapped ? r_minor_pos : r_major_pos;
    assign cur_y  = r_swapped ? r_major_pos : r_minor_pos;
    assign px_ext = {{FIELD_BITS{1'b0}}, cur_x};
    assign py_ext = {{FIELD_BITS{1'b0}}, cur_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major_pos   <= '0;
            r_minor_pos   <= '0;
            r_major_delta <= '0;
            r_minor_delta <= '0;
            r_error       <= '0;
            r_major_neg   <= 1'b0;
            r_minor_neg   <= 1'b0;
            r_swapped     <= 1'b0;
            r_color       <= 1'b0;
            r_active      <= 1'b0;
            r_pixels_left <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_major_pos   <= n_major_pos;
            r_minor_pos   <= n_minor_pos;
            r_major_delta <= n_major_delta;
            r_minor_delta <= n_minor_delta;
            r_error       <= n_error;
            r_major_neg   <= n_major_neg;
            r_minor_neg   <= n_minor_neg;
            r_swapped     <= n_swapped;
            r_color       <= n_color;
            r_active      <= n_active;
            r_pixels_left <= n_pixels_left;
            if (step_emit) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the result register, no reset
    always_ff @(posedge i_clk) begin
        if (step_emit) begin
            r_px     <= px_ext[FIELD_BITS-1:0];
            r_py     <= py_ext[FIELD_BITS-1:0];
            r_pcolor <= r_color;
            r_plast  <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_last        = r_plast;

    `BRL_ASSERT_ALWAYS(a_active_has_pixels, i_clk, i_rst_n, !r_active || (r_pixels_left != '0))
    `BRL_ASSERT_ALWAYS(a_count_bounded, i_clk, i_rst_n, r_pixels_left <= ({1'b0, r_major_delta} + (W+1)'(1)))
    `BRL_ASSERT_NEXT(a_load_activates, i_clk, i_rst_n, in_fire && (i_op == OP_LOAD), r_active)
    `BRL_ASSERT_NEXT(a_last_goes_idle, i_clk, i_rst_n, step_emit && is_last, !r_active && r_out_valid && o_last)

endmodule

FILE: sim/tb.sv
// Self-checking bench for bresenham_line_rasterizer_core: queued load/step traffic,
// an in-bench line walker that predicts every pixel, and random idling on both channels.
// Depends on brl_pkg and the RTL core only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brl_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    typedef struct {
        logic       op;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;
        logic       color;
    } line_cmd_t;

    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic       last;
    } pixel_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_op = 1'b0;
    logic [7:0] i_x_start = '0;
    logic [7:0] i_y_start = '0;
    logic [7:0] i_x_end = '0;
    logic [7:0] i_y_end = '0;
    logic       i_color = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_pixel_x;
    logic [7:0] o_pixel_y;
    logic       o_pixel_color;
    logic       o_last;

    bresenham_line_rasterizer_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_x_start     (i_x_start),
        .i_y_start     (i_y_start),
        .i_x_end       (i_x_end),
        .i_y_end       (i_y_end),
        .i_color       (i_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

    line_cmd_t   cmd_q[$];
    pixel_t      pixel_q[$];
    line_cmd_t   cur_cmd;
    int          in_gap = 0;
    int          out_stall = 0;
    int unsigned cycle_cnt = 0;
    int          n_errors = 0;

    // Line walker state, cleared as after reset
    logic [CB-1:0]      walk_major = '0;
    logic [CB-1:0]      walk_minor = '0;
    logic signed [10:0] walk_err = '0;
    logic [CB-1:0]      delta_major = '0;
    logic [CB-1:0]      delta_minor = '0;
    logic               major_back = 1'b0;
    logic               minor_back = 1'b0;
    logic               y_major = 1'b0;
    logic [8:0]         pixels_todo = '0;
    logic               walk_color = 1'b0;
    logic               walk_busy = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Idle length: none during calm stretches, otherwise mostly short, a few long
    function automatic int gap_len();
        int r;
        if ((cycle_cnt / 150) % 4 == 0) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the walker by one accepted transaction; queue the pixel it yields
    function automatic void rasterize(line_cmd_t c);
        logic [CB-1:0] dx, dy;
        pixel_t        px;
        if (c.op == OP_LOAD) begin
            dx = (c.x1 > c.x0) ? c.x1 - c.x0 : c.x0 - c.x1;
            dy = (c.y1 > c.y0) ? c.y1 - c.y0 : c.y0 - c.y1;
            walk_color = c.color;
            y_major = (dy > dx);
            if (y_major) begin
                walk_major  = c.y0;
                walk_minor  = c.x0;
                delta_major = dy;
                delta_minor = dx;
                major_back  = !(c.y1 > c.y0);
                minor_back  = !(c.x1 > c.x0);
            end else begin
                walk_major  = c.x0;
                walk_minor  = c.y0;
                delta_major = dx;
                delta_minor = dy;
                major_back  = !(c.x1 > c.x0);
                minor_back  = !(c.y1 > c.y0);
            end
            walk_err = $signed({2'b0, delta_minor, 1'b0}) - $signed({3'b0, delta_major});
            pixels_todo = {1'b0, delta_major} + 9'd1;
            walk_busy = 1'b1;
            return;
        end
        if (!walk_busy) return;
        px.x = y_major ? walk_minor : walk_major;
        px.y = y_major ? walk_major : walk_minor;
        px.color = walk_color;
        px.last = (pixels_todo <= 9'd1);
        pixel_q.push_back(px);
        if (px.last) begin
            pixels_todo = '0;
            walk_busy = 1'b0;
        end else begin
            pixels_todo = pixels_todo - 9'd1;
            if (walk_err >= 0) begin
                walk_minor = minor_back ? walk_minor - CB'(1) : walk_minor + CB'(1);
                walk_err = walk_err - $signed({2'b0, delta_major, 1'b0});
            end
            walk_major = major_back ? walk_major - CB'(1) : walk_major + CB'(1);
            walk_err = walk_err + $signed({2'b0, delta_minor, 1'b0});
        end
    endfunction

    task automatic queue_load(logic [7:0] x0, logic [7:0] y0, logic [7:0] x1,
                              logic [7:0] y1, logic color);
        line_cmd_t c;
        c.op = OP_LOAD;
        c.x0 = x0;
        c.y0 = y0;
        c.x1 = x1;
        c.y1 = y1;
        c.color = color;
        cmd_q.push_back(c);
    endtask

    // Step transactions carry random (ignored) coordinates so every input bit toggles
    task automatic queue_steps(int n);
        line_cmd_t c;
        repeat (n) begin
            c.op = OP_STEP;
            c.x0 = 8'($urandom);
            c.y0 = 8'($urandom);
            c.x1 = 8'($urandom);
            c.y1 = 8'($urandom);
            c.color = 1'($urandom);
            cmd_q.push_back(c);
        end
    endtask

    function automatic logic [7:0] near_coord(logic [7:0] base);
        int v;
        v = int'(base) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                rasterize(cur_cmd);
                in_gap = gap_len();
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (cmd_q.size() > 0) begin
                    cur_cmd = cmd_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_op      <= cur_cmd.op;
                    i_x_start <= cur_cmd.x0;
                    i_y_start <= cur_cmd.y0;
                    i_x_end   <= cur_cmd.x1;
                    i_y_end   <= cur_cmd.y1;
                    i_color   <= cur_cmd.color;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and sink backpressure
    always @(posedge i_clk) begin
        pixel_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pixel_q.size() == 0) begin
                    $display("%0t: pixel with none expected: x=%0d y=%0d color=%0b last=%0b",
                             $time, o_pixel_x, o_pixel_y, o_pixel_color, o_last);
                    n_errors++;
                end else begin
                    want = pixel_q.pop_front();
                    if (o_pixel_x !== want.x) begin
                        $display("%0t: pixel_x expected %0d got %0d", $time, want.x, o_pixel_x);
                        n_errors++;
                    end
                    if (o_pixel_y !== want.y) begin
                        $display("%0t: pixel_y expected %0d got %0d", $time, want.y, o_pixel_y);
                        n_errors++;
                    end
                    if (o_pixel_color !== want.color) begin
                        $display("%0t: pixel_color expected %0b got %0b",
                                 $time, want.color, o_pixel_color);
                        n_errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %0b got %0b", $time, want.last, o_last);
                        n_errors++;
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                out_stall = ($urandom_range(3) == 0) ? gap_len() : 0;
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        logic [7:0] x0, y0, x1, y1;
        int         len, n, r;

        // directed part
        queue_steps(1);                                 // step while idle
        queue_load(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);       // zero-length line
        queue_steps(2);
        queue_load(8'd255, 8'd255, 8'd0, 8'd0, 1'b0);   // equal deltas, both axes back
        queue_steps(2);
        queue_load(8'd0, 8'd255, 8'd255, 8'd0, 1'b1);   // abandons the line above
        queue_steps(1);
        queue_load(8'd5, 8'd5, 8'd7, 8'd9, 1'b1);       // steep, axes swapped
        queue_steps(5);
        queue_load(8'd200, 8'd250, 8'd197, 8'd246, 1'b0);
        queue_steps(5);
        queue_load(8'd3, 8'd9, 8'd7, 8'd9, 1'b1);       // flat, minor axis does not move
        queue_steps(2);

        // random lines, mostly well-formed walks with some noise
        while (cmd_q.size() < 700) begin
            r = $urandom_range(99);
            if (r < 6) begin
                if ($urandom_range(1)) queue_steps(1);
                else queue_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                1'($urandom));
            end else begin
                x0 = 8'($urandom);
                y0 = 8'($urandom);
                if ($urandom_range(9) < 8) begin
                    x1 = near_coord(x0);
                    y1 = near_coord(y0);
                end else begin
                    x1 = 8'($urandom);
                    y1 = 8'($urandom);
                end
                len = (x1 > x0) ? int'(x1 - x0) : int'(x0 - x1);
                n = (y1 > y0) ? int'(y1 - y0) : int'(y0 - y1);
                if (n > len) len = n;
                len++;
                r = $urandom_range(9);
                if (r < 7) n = len;
                else if (r == 7) n = $urandom_range(len - 1);
                else n = len + $urandom_range(1, 3);
                queue_load(x0, y0, x1, y1, 1'($urandom));
                queue_steps(n);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() > 0 || i_in_valid) @(posedge i_clk);
        while (pixel_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/brl_pkg.sv
rtl/bresenham_line_rasterizer_core.sv
sim/tb.sv
